// ===== hw/rtl/bdar_pkg.sv =====
`timescale 1ns / 1ps

package bdar_pkg;

  // Field widths fixed by the stream format
  localparam int OP_W     = 2;
  localparam int PINS_W   = 4;
  localparam int BTN_W    = 3;
  localparam int TICKS_W  = 16;
  localparam int VIEW_W   = 4;   // buttons shown in flags and levels
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_SET   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSED_LEVEL = 1'd0,
    REG_REPEAT_TICKS  = 1'd1
  } reg_idx_t;

  localparam logic [TICKS_W-1:0] REPEAT_TICKS_RST = 16'd100;

  typedef struct packed {
    logic                pressed_level;
    logic [TICKS_W-1:0]  repeat_ticks;
  } cfg_t;

  // One-hot per lane: at most one of these is high in a cycle
  typedef struct packed {
    logic tick;
    logic query;
    logic set;
  } lane_ctl_t;

  typedef struct packed {
    logic answer;
    logic flag_next;
    logic level_next;
    logic flag;
    logic level;
  } lane_stat_t;

  // pressed sits in the lowest bit
  typedef struct packed {
    logic [VIEW_W-1:0] levels;
    logic [VIEW_W-1:0] flags;
    logic              pressed;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hw/rtl/bdar_lane.sv =====
`timescale 1ns / 1ps

module bdar_lane (
  input  logic              clk,
  input  logic              rst,
  input  bdar_pkg::cfg_t      cfg,
  input  bdar_pkg::lane_ctl_t ctl,
  input  logic              pin,
  output bdar_pkg::lane_stat_t stat
);
  import bdar_pkg::*;

  logic               newest, middle, oldest, level, flag;
  logic [TICKS_W-1:0] count;
  logic               newest_next, middle_next, oldest_next, level_next, flag_next;
  logic [TICKS_W-1:0] count_next;
  logic [TICKS_W-1:0] count_dec;
  logic               agree;
  logic               answer;

  assign agree     = (middle == newest) && (newest == pin);
  assign count_dec = (count != '0) ? count - TICKS_W'(1) : '0;

  always_comb begin
    newest_next = newest;
    middle_next = middle;
    oldest_next = oldest;
    level_next  = level;
    flag_next   = flag;
    count_next  = count;
    answer      = 1'b0;
    if (ctl.tick) begin
      oldest_next = middle;
      middle_next = newest;
      newest_next = pin;
      if (agree) begin
        if (pin != level) begin
          level_next = pin;
          if (pin == cfg.pressed_level) begin
            flag_next  = 1'b1;
            count_next = cfg.repeat_ticks;
          end
        end else begin
          // held steady: run the repeat timer, release at zero to re-trigger
          count_next = count_dec;
          if (count_dec == '0) begin
            level_next = ~cfg.pressed_level;
          end
        end
      end
    end
    if (ctl.query) begin
      answer    = flag;
      flag_next = 1'b0;
    end
    if (ctl.set) begin
      flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest <= 1'b0;
      middle <= 1'b0;
      oldest <= 1'b0;
      level  <= 1'b1;
      flag   <= 1'b0;
      count  <= '0;
    end else begin
      newest <= newest_next;
      middle <= middle_next;
      oldest <= oldest_next;
      level  <= level_next;
      flag   <= flag_next;
      count  <= count_next;
    end
  end

  assign stat.answer     = answer;
  assign stat.flag_next  = flag_next;
  assign stat.level_next = level_next;
  assign stat.flag       = flag;
  assign stat.level      = level;

endmodule

// ===== hw/rtl/bdar_skid.sv =====
`timescale 1ns / 1ps

module bdar_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdar_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bdar_pkg::result_t out_data
);
  import bdar_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    push, pop;

  assign in_ready = ~skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (push) begin
      skid_data <= in_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !skid_valid && !push) |=> !out_valid)
    else $error("output stays valid after its beat was taken");

endmodule

// ===== hw/rtl/button_debounce_auto_repeat.sv =====
// Four-button debouncer with auto-repeat, one lane per button.
// The result beat is registered in the output buffer ahead of m_tvalid/m_tdata.
// Throughput: one beat per cycle while the skid is empty; all lanes update in parallel
// in the accept cycle; a two-entry output buffer keeps s_tready high over one stall.
// Reset (rst, synchronous): samples, flags and repeat counters clear, every button
// reads released, pressed_level = 0, repeat_ticks = 100, output buffer empty.
`timescale 1ns / 1ps

module button_debounce_auto_repeat #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream. s_tdata, low bit up: op[1:0], pin_levels[5:2], button[8:6], zero fill
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bdar_pkg::S_DATA_W-1:0]       s_tdata,
  // Result stream. m_tdata, low bit up: pressed[0], flags[4:1], levels[8:5], zero fill
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bdar_pkg::M_DATA_W-1:0]       m_tdata,
  // Configuration: index 0 pressed_level, index 1 repeat_ticks
  input  logic                                cfg_we,
  input  logic [bdar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdar_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bdar_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. User writes only while the block is idle; not enforced.
  // ---------------------------------------------------------------------------
  logic               pressed_level;
  logic [TICKS_W-1:0] repeat_ticks;
  cfg_t               cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_level <= 1'b0;
      repeat_ticks  <= REPEAT_TICKS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PRESSED_LEVEL: pressed_level <= cfg_data[0];
        REG_REPEAT_TICKS:  repeat_ticks  <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pressed_level = pressed_level;
  assign cfg.repeat_ticks  = repeat_ticks;

  // ---------------------------------------------------------------------------
  // Unpack the input beat and decode the operation.
  // ---------------------------------------------------------------------------
  op_t               op;
  logic [PINS_W-1:0] pin_levels;
  logic [BTN_W-1:0]  button;
  logic              push;

  assign op         = op_t'(s_tdata[OP_W-1:0]);
  assign pin_levels = s_tdata[OP_W +: PINS_W];
  assign button     = s_tdata[OP_W+PINS_W +: BTN_W];
  assign push       = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Lanes. Each lane owns one button's history, level, flag and repeat timer.
  // A tick fans out to every lane; a query or set reaches only the lane whose
  // index matches, so an index at or beyond NUM_BUTTONS hits nothing.
  // ---------------------------------------------------------------------------
  lane_stat_t             stat [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] answer_vec;
  logic [NUM_BUTTONS-1:0] flag_vec;
  logic [NUM_BUTTONS-1:0] level_vec;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    localparam logic [31:0] IDX = 32'(i);
    lane_ctl_t ctl;
    logic      hit;
    logic      pin;

    assign hit       = (32'(button) == IDX);
    assign ctl.tick  = push && (op == OP_TICK);
    assign ctl.query = push && (op == OP_QUERY) && hit;
    assign ctl.set   = push && (op == OP_SET) && hit;

    // Buttons past the pin field always sample a low level
    if (i < PINS_W) begin : g_pin
      assign pin = pin_levels[i];
    end else begin : g_nopin
      assign pin = 1'b0;
    end

    bdar_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .cfg  (cfg),
      .ctl  (ctl),
      .pin  (pin),
      .stat (stat[i])
    );

    assign answer_vec[i] = stat[i].answer;
    assign flag_vec[i]   = stat[i].flag;
    assign level_vec[i]  = stat[i].level;
  end

  // ---------------------------------------------------------------------------
  // Merge: OR the lane answers, gather the post-item flags and levels of the
  // first four buttons, zero-fill where there are fewer.
  // ---------------------------------------------------------------------------
  result_t result;

  assign result.pressed = |answer_vec;

  for (genvar j = 0; j < VIEW_W; j++) begin : g_view
    if (j < NUM_BUTTONS) begin : g_on
      assign result.flags[j]  = stat[j].flag_next;
      assign result.levels[j] = stat[j].level_next;
    end else begin : g_off
      assign result.flags[j]  = 1'b0;
      assign result.levels[j] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry: accept while one result waits.
  // ---------------------------------------------------------------------------
  result_t out_res;

  bdar_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {{(M_DATA_W-RESULT_W){1'b0}}, out_res};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_flags_clear_only_on_query: assert property (@(posedge clk) disable iff (rst)
    !(push && (op == OP_QUERY)) |=> ((flag_vec & $past(flag_vec)) == $past(flag_vec)))
    else $error("press flag dropped without a query");

  a_levels_move_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(push && (op == OP_TICK)) |=> $stable(level_vec))
    else $error("debounced level changed outside a tick");

  a_answer_only_on_query: assert property (@(posedge clk) disable iff (rst)
    result.pressed |-> (push && (op == OP_QUERY)))
    else $error("press answer raised outside a query");

endmodule

// ===== sim/button_debounce_auto_repeat_test.sv =====
`timescale 1ns / 1ps

module button_debounce_auto_repeat_test;
  import bdar_pkg::*;

  // Tracks what the debouncer should return for each accepted input beat and
  // compares result beats in order.
  class debounce_scoreboard;
    int unsigned num_buttons;
    bit          press_pol;
    bit [15:0]   reload_ticks;
    bit [3:0]    newest, middle, oldest, level, flag;
    bit [15:0]   hold_count[4];
    result_t     expected_q[$];
    int          mismatches;
    int          checked;

    function new(int unsigned buttons);
      num_buttons = buttons;
      mismatches  = 0;
      checked     = 0;
      clear();
    endfunction

    function void clear();
      press_pol    = 1'b0;
      reload_ticks = REPEAT_TICKS_RST;
      newest       = '0;
      middle       = '0;
      oldest       = '0;
      level        = 4'b1111;
      flag         = '0;
      foreach (hold_count[i]) hold_count[i] = '0;
      expected_q.delete();
    endfunction

    function void write_reg(reg_idx_t idx, bit [15:0] val);
      case (idx)
        REG_PRESSED_LEVEL: press_pol    = val[0];
        REG_REPEAT_TICKS:  reload_ticks = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_beat(logic [15:0] data);
      op_t     op;
      bit [3:0] pins;
      bit [2:0] btn;
      result_t  want;
      op   = op_t'(data[1:0]);
      pins = data[5:2];
      btn  = data[8:6];
      want = '0;
      case (op)
        OP_TICK: begin
          for (int i = 0; i < 4; i++) begin
            oldest[i] = middle[i];
            middle[i] = newest[i];
            newest[i] = pins[i];
            if (oldest[i] == middle[i] && middle[i] == newest[i]) begin
              if (newest[i] != level[i]) begin
                level[i] = newest[i];
                if (level[i] == press_pol) begin
                  flag[i]       = 1'b1;
                  hold_count[i] = reload_ticks;
                end
              end else begin
                if (hold_count[i] != 0) hold_count[i] = hold_count[i] - 1'b1;
                if (hold_count[i] == 0) level[i] = ~press_pol;
              end
            end
          end
        end
        OP_QUERY: begin
          if (btn < num_buttons && flag[btn]) begin
            flag[btn]    = 1'b0;
            want.pressed = 1'b1;
          end
        end
        OP_SET: begin
          if (btn < num_buttons) flag[btn] = 1'b1;
        end
        default: ;
      endcase
      want.flags  = flag;
      want.levels = level;
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 100)
        $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    task check_beat(logic [15:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[RESULT_W-1:0]);
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", data, 0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.pressed !== want.pressed) report_mismatch("pressed", got.pressed, want.pressed);
      if (got.flags !== want.flags) report_mismatch("flags", got.flags, want.flags);
      if (got.levels !== want.levels) report_mismatch("levels", got.levels, want.levels);
      if (data[15:RESULT_W] !== '0) report_mismatch("zero fill", data[15:RESULT_W], 0);
    endtask

    task flush_leftovers();
      result_t want;
      while (expected_q.size() != 0) begin
        want = expected_q.pop_front();
        report_mismatch("result never arrived", want, want);
      end
    endtask
  endclass

  localparam int NUM_BUTTONS = 4;
  localparam int HOLD_OFF_CYCLES = 150;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;    // op[1:0], pin_levels[5:2], button[8:6], zero fill
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;    // pressed[0], flags[4:1], levels[8:5], zero fill
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  debounce_scoreboard sb;

  int gap_pct;         // chance in 100 that the source idles after a beat
  int stall_pct;       // chance in 100 that the sink stalls a cycle
  logic hold_results;  // sink holds off entirely while high
  int items_sent;
  int settings_used;

  button_debounce_auto_repeat #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run, even with every stall.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Sink side: stall at the current rate, or hold off completely while the
  // pressure test asks for it.
  always @(posedge clk) begin
    if (hold_results) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Note every accepted input beat, then check every accepted result beat.
  // Results are registered after their inputs, so the order here is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_beat(s_tdata);
      if (m_tvalid && m_tready) sb.check_beat(m_tdata);
    end
  end

  // Offer one beat and hold it until accepted; then maybe idle for a while.
  // Valid is lowered only when a gap follows, so it is never lowered and
  // raised in the same step.
  task automatic send_item(op_t op, logic [3:0] pins, logic [2:0] btn);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, btn, pins, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every outstanding result has come back, then let
  // the output register and skid entry settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; the wait after lowering the enable keeps it from being
  // dropped and raised in the same step on back-to-back writes.
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [2:0] pick_button();
    if ($urandom_range(0, 4) == 0) return 3'($urandom_range(4, 7));
    return 3'($urandom_range(0, 3));
  endfunction

  // Mostly held pin patterns long enough to get past the three-sample filter,
  // with occasional bounce, mixed with queries, sets and some noise.
  task automatic random_burst(int count);
    int       sent;
    int       kind;
    int       len;
    int       k;
    logic [3:0] pins;
    logic [3:0] bounce;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        pins = 4'($urandom_range(0, 15));
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          bounce = ($urandom_range(0, 9) == 0) ? (4'b0001 << $urandom_range(0, 3)) : 4'b0000;
          send_item(OP_TICK, pins ^ bounce, 3'($urandom_range(0, 7)));
          sent++;
        end
      end else if (kind < 80) begin
        send_item(OP_QUERY, 4'($urandom_range(0, 15)), pick_button());
        sent++;
      end else if (kind < 90) begin
        send_item(OP_SET, 4'($urandom_range(0, 15)), pick_button());
        sent++;
      end else if (kind < 96) begin
        send_item(OP_TICK, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
        sent++;
      end else begin
        send_item(OP_NONE, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
        sent++;
      end
    end
  endtask

  // Reprogram while idle, set the idling rates, then run random traffic.
  task automatic run_phase(logic pol, logic [15:0] ticks, int gap, int stall, int count);
    write_reg(REG_PRESSED_LEVEL, {15'd0, pol});
    write_reg(REG_REPEAT_TICKS, ticks);
    settings_used++;
    gap_pct = gap;
    stall_pct <= stall;
    random_burst(count);
    drain();
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_PRESSED_LEVEL;
    cfg_data     = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_results = 1'b0;
    items_sent   = 0;
    settings_used = 1;
    sb = new(NUM_BUTTONS);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    sb.clear();
    @(posedge clk);

    // Directed part under reset settings: pressed is low, so every button
    // starts released at level 1.
    send_item(OP_NONE, 4'b1111, 3'd7);      // unknown op changes nothing
    send_item(OP_QUERY, 4'b0000, 3'd0);     // nothing raised yet
    send_item(OP_SET, 4'b0000, 3'd7);       // out-of-range set is ignored
    send_item(OP_SET, 4'b0000, 3'd4);
    send_item(OP_SET, 4'b0000, 3'd3);
    send_item(OP_QUERY, 4'b0000, 3'd3);     // reads and clears
    send_item(OP_QUERY, 4'b0000, 3'd3);
    send_item(OP_QUERY, 4'b0000, 3'd5);     // out-of-range query reads 0
    repeat (3) send_item(OP_TICK, 4'b0000, 3'd0);  // history starts low: all pressed at once
    repeat (3) send_item(OP_TICK, 4'b1111, 3'd7);  // all released again
    send_item(OP_TICK, 4'b0101, 3'd2);      // bounce never settles
    send_item(OP_TICK, 4'b1010, 3'd5);
    send_item(OP_QUERY, 4'b0000, 3'd0);
    send_item(OP_QUERY, 4'b0000, 3'd1);
    send_item(OP_QUERY, 4'b0000, 3'd2);
    send_item(OP_QUERY, 4'b0000, 3'd3);
    drain();

    // Zero repeat count: a held press re-triggers on every other agreeing tick.
    write_reg(REG_REPEAT_TICKS, 16'd0);
    settings_used++;
    repeat (5) send_item(OP_TICK, 4'b0000, 3'd1);
    drain();

    // Random phases across both polarities and the repeat extremes.
    run_phase(1'b1, 16'd1, 0, 0, 270);
    run_phase(1'b0, 16'd3, 59, 0, 270);
    run_phase(1'b1, 16'hFFFF, 0, 59, 270);
    run_phase(1'b0, 16'd5, 7, 7, 270);

    // Pressure: the sink holds off for a long stretch while the source keeps
    // offering beats, so the output buffer fills and input ready drops.
    write_reg(REG_PRESSED_LEVEL, 16'd1);
    write_reg(REG_REPEAT_TICKS, 16'd2);
    settings_used++;
    gap_pct = 0;
    stall_pct <= 0;
    fork
      begin
        hold_results <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
      end
      random_burst(40);
    join
    random_burst(230);
    drain();

    repeat (8) @(posedge clk);
    sb.flush_leftovers();

    $display("Covered %0d input beats and %0d result beats over %0d register settings,",
             items_sent, sb.checked, settings_used);
    $display("with source gaps, sink stalls and one long sink hold-off.");
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bdar_pkg.sv
hw/rtl/bdar_lane.sv
hw/rtl/bdar_skid.sv
hw/rtl/button_debounce_auto_repeat.sv
sim/button_debounce_auto_repeat_test.sv
